// ===== hw/rtl/fste_pkg.sv =====
// Shared types, constants and codes for the flat shaded triangle expander.
// No dependencies; used by fste_ctrl, fste_dp, the top level and the checker.
package fste_pkg;

	// Default vertex store depth.
	localparam int unsigned VERTEX_DEPTH_DEF = 1024;

	// Field widths fixed by the stream format.
	localparam int unsigned POS_W  = 24;
	localparam int unsigned IDX_W  = 16;
	localparam int unsigned NRM_W  = 16;
	localparam int unsigned DATA_W = 120;

	// Datapath internal widths.
	localparam int unsigned DIF_W = 25;   // edge difference
	localparam int unsigned MOP_W = 31;   // multiplier operand
	localparam int unsigned PRD_W = 62;   // multiplier product
	localparam int unsigned CR_W  = 51;   // cross product component, signed
	localparam int unsigned MAG_W = 50;   // cross product magnitude
	localparam int unsigned SQ_W  = 62;   // sum of squares, root work registers
	localparam int unsigned LEN_W = 32;   // vector length
	localparam int unsigned QUO_W = 17;   // quotient bits per lane
	localparam int unsigned NUM_W = 46;   // dividend width

	// Iteration counts.
	localparam int unsigned SQRT_STEPS = 31;
	localparam int unsigned CROSS_STEPS = 6;
	localparam int unsigned SQ_STEPS = 3;
	localparam int unsigned CORNERS = 3;

	// Input command codes (tuser).
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_FACE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE,
		OP_LOAD,
		OP_READ,
		OP_DIFF,
		OP_CROSS,
		OP_MAG,
		OP_NORM,
		OP_SQUARE,
		OP_SQINIT,
		OP_SQRT,
		OP_DIVINIT,
		OP_DIV,
		OP_FIN,
		OP_EMIT
	} op_t;

	// Command from controller to datapath.
	typedef struct packed {
		op_t        op;
		logic [2:0] sel;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic all_ok;
		logic zero;
		logic norm_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/fste_ctrl.sv =====
// Sequencing state machine of the triangle expander.
// Depends on fste_pkg; drives fste_dp through dp_cmd_t and reads dp_stat_t.
module fste_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  fste_pkg::dp_stat_t stat,
	output fste_pkg::dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_RDW, S_DIFF, S_CROSS, S_CDRAIN, S_MAG,
		S_NORM, S_SQ, S_SQDRAIN, S_SQINIT, S_SQRT, S_DIVINIT, S_DIV, S_FIN, S_EMIT
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] step_q, step_d;

	// Decode state into the datapath command and next state.
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd.op   = fste_pkg::OP_NONE;
		cmd.sel  = step_q[2:0];
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == fste_pkg::CMD_STORE) begin
						cmd.op = fste_pkg::OP_STORE;
					end else begin
						cmd.op  = fste_pkg::OP_LOAD;
						state_d = S_RD0;
					end
				end
			end
			S_RD0: begin
				cmd.op = fste_pkg::OP_READ; cmd.sel = 3'd0; state_d = S_RD1;
			end
			S_RD1: begin
				cmd.op = fste_pkg::OP_READ; cmd.sel = 3'd1; state_d = S_RD2;
			end
			S_RD2: begin
				cmd.op = fste_pkg::OP_READ; cmd.sel = 3'd2; state_d = S_RDW;
			end
			S_RDW: begin
				step_d  = '0;
				state_d = stat.all_ok ? S_DIFF : S_EMIT;
			end
			S_DIFF: begin
				cmd.op = fste_pkg::OP_DIFF; step_d = '0; state_d = S_CROSS;
			end
			S_CROSS: begin
				cmd.op = fste_pkg::OP_CROSS;
				if (step_q == 5'(fste_pkg::CROSS_STEPS - 1)) begin
					step_d = '0; state_d = S_CDRAIN;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			S_CDRAIN: state_d = S_MAG;
			S_MAG: begin
				cmd.op  = fste_pkg::OP_MAG;
				step_d  = '0;
				state_d = stat.zero ? S_EMIT : S_NORM;
			end
			S_NORM: begin
				if (stat.norm_done) begin
					step_d = '0; state_d = S_SQ;
				end else begin
					cmd.op = fste_pkg::OP_NORM;
				end
			end
			S_SQ: begin
				cmd.op = fste_pkg::OP_SQUARE;
				if (step_q == 5'(fste_pkg::SQ_STEPS - 1)) begin
					step_d = '0; state_d = S_SQDRAIN;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			S_SQDRAIN: state_d = S_SQINIT;
			S_SQINIT: begin
				cmd.op = fste_pkg::OP_SQINIT; step_d = '0; state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = fste_pkg::OP_SQRT;
				if (step_q == 5'(fste_pkg::SQRT_STEPS - 1)) begin
					step_d = '0; state_d = S_DIVINIT;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			S_DIVINIT: begin
				cmd.op = fste_pkg::OP_DIVINIT; step_d = '0; state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = fste_pkg::OP_DIV;
				if (step_q == 5'(fste_pkg::QUO_W - 1)) begin
					step_d = '0; state_d = S_FIN;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			S_FIN: begin
				cmd.op = fste_pkg::OP_FIN; step_d = '0; state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op = fste_pkg::OP_EMIT;
					if (step_q == 5'(fste_pkg::CORNERS - 1)) begin
						step_d = '0; state_d = S_IDLE;
					end else begin
						step_d = step_q + 5'd1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and step count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

// ===== hw/rtl/fste_dp.sv =====
// Datapath of the triangle expander: vertex store, cross product, normalize,
// square root, three divider lanes and the output register. Depends on fste_pkg.
module fste_dp #(
	parameter int unsigned VERTEX_DEPTH = fste_pkg::VERTEX_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fste_pkg::dp_cmd_t          cmd,
	output fste_pkg::dp_stat_t         stat,
	input  logic [fste_pkg::DATA_W-1:0] in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fste_pkg::DATA_W-1:0] out_data,
	output logic [3:0]                 out_user,
	output logic                       out_last
);

	localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int unsigned CW = $clog2(VERTEX_DEPTH + 1);
	localparam int unsigned PW = fste_pkg::POS_W;
	localparam int unsigned IW = fste_pkg::IDX_W;
	localparam int unsigned DW = fste_pkg::DIF_W;
	localparam int unsigned OW = fste_pkg::MOP_W;
	localparam int unsigned RW = fste_pkg::CR_W;
	localparam int unsigned MW = fste_pkg::MAG_W;
	localparam int unsigned SW = fste_pkg::SQ_W;
	localparam int unsigned LW = fste_pkg::LEN_W;
	localparam int unsigned QW = fste_pkg::QUO_W;
	localparam int unsigned NW = fste_pkg::NUM_W;
	localparam int unsigned HW = fste_pkg::NRM_W;

	// Vertex store.
	logic [PW-1:0] mem_x [VERTEX_DEPTH];
	logic [PW-1:0] mem_y [VERTEX_DEPTH];
	logic [PW-1:0] mem_z [VERTEX_DEPTH];
	logic [CW-1:0] cnt_q;
	logic          full;

	// Face registers.
	logic [IW-1:0] idx_q [3];
	logic [2:0]    ok_q;
	logic [IW-1:0] in_idx [3];
	logic [2:0]    in_ok;
	logic [PW-1:0] vx_q [3];
	logic [PW-1:0] vy_q [3];
	logic [PW-1:0] vz_q [3];
	logic [PW-1:0] rx_s1, ry_s1, rz_s1;
	logic          rvld_s1;
	logic [1:0]    rsel_s1;
	logic [IW-1:0] rd_m1;
	logic [AW-1:0] rd_addr;

	// Arithmetic registers.
	logic signed [DW-1:0] ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [2*OW-1:0] prod_s1;
	logic                 mvld_s1, msq_s1;
	logic [2:0]           mstep_s1;
	logic signed [RW-1:0] cr_q [3];
	logic [MW-1:0]        m_q [3];
	logic                 norm_hi, norm_lo;
	logic [SW-1:0]        sum_q, sq_n_q, sq_r_q, sq_b_q, sq_t;
	logic [LW-1:0]        len;
	logic [LW:0]          rem_q [3];
	logic [QW-1:0]        nlo_q [3];
	logic [QW-1:0]        quo_q [3];
	logic [HW-1:0]        nrm_q [3];
	logic [1:0]           status_q;

	assign full = (cnt_q >= CW'(VERTEX_DEPTH));

	// Unpack face indices and check them against the store fill.
	always_comb begin
		in_idx[0] = in_data[87:72];
		in_idx[1] = in_data[103:88];
		in_idx[2] = in_data[119:104];
		for (int k = 0; k < 3; k++) begin
			in_ok[k] = (in_idx[k] != '0) && ({1'b0, in_idx[k]} <= (IW+1)'(cnt_q));
		end
	end

	// Store fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.op == fste_pkg::OP_STORE && !full) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign rd_m1   = idx_q[cmd.sel[1:0]] - IW'(1);
	assign rd_addr = ok_q[cmd.sel[1:0]] ? rd_m1[AW-1:0] : '0;

	// Write and read the store.
	always_ff @(posedge clk) begin
		if (cmd.op == fste_pkg::OP_STORE && !full) begin
			mem_x[cnt_q[AW-1:0]] <= in_data[23:0];
			mem_y[cnt_q[AW-1:0]] <= in_data[47:24];
			mem_z[cnt_q[AW-1:0]] <= in_data[71:48];
		end
		if (cmd.op == fste_pkg::OP_READ) begin
			rx_s1 <= mem_x[rd_addr];
			ry_s1 <= mem_y[rd_addr];
			rz_s1 <= mem_z[rd_addr];
		end
	end

	// Read and multiplier tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			mvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= (cmd.op == fste_pkg::OP_READ);
			mvld_s1 <= (cmd.op == fste_pkg::OP_CROSS) || (cmd.op == fste_pkg::OP_SQUARE);
		end
	end

	// Select multiplier operands per step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.op == fste_pkg::OP_SQUARE) begin
			mul_a = OW'(signed'({1'b0, m_q[cmd.sel[1:0]][29:0]}));
			mul_b = mul_a;
		end else begin
			case (cmd.sel)
				3'd0: begin mul_a = OW'(uy_q); mul_b = OW'(wz_q); end
				3'd1: begin mul_a = OW'(uz_q); mul_b = OW'(wy_q); end
				3'd2: begin mul_a = OW'(uz_q); mul_b = OW'(wx_q); end
				3'd3: begin mul_a = OW'(ux_q); mul_b = OW'(wz_q); end
				3'd4: begin mul_a = OW'(ux_q); mul_b = OW'(wy_q); end
				3'd5: begin mul_a = OW'(uy_q); mul_b = OW'(wx_q); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign norm_hi = |{m_q[0][MW-1:30], m_q[1][MW-1:30], m_q[2][MW-1:30]};
	assign norm_lo = ~|{m_q[0][MW-1:29], m_q[1][MW-1:29], m_q[2][MW-1:29]};
	assign sq_t    = sq_r_q + sq_b_q;
	assign len     = sq_r_q[LW-1:0];

	// Main datapath registers.
	always_ff @(posedge clk) begin
		prod_s1  <= mul_a * mul_b;
		msq_s1   <= (cmd.op == fste_pkg::OP_SQUARE);
		mstep_s1 <= cmd.sel;
		rsel_s1  <= cmd.sel[1:0];
		if (rvld_s1) begin
			vx_q[rsel_s1] <= rx_s1;
			vy_q[rsel_s1] <= ry_s1;
			vz_q[rsel_s1] <= rz_s1;
		end
		// Accumulate cross products and squares.
		if (mvld_s1) begin
			if (msq_s1) begin
				sum_q <= (mstep_s1 == 3'd0 ? '0 : sum_q) + SW'(unsigned'(prod_s1));
			end else if (!mstep_s1[0]) begin
				cr_q[mstep_s1[2:1]] <= RW'(prod_s1);
			end else begin
				cr_q[mstep_s1[2:1]] <= cr_q[mstep_s1[2:1]] - RW'(prod_s1);
			end
		end
		case (cmd.op)
			fste_pkg::OP_LOAD: begin
				for (int k = 0; k < 3; k++) begin
					idx_q[k] <= in_idx[k];
					ok_q[k]  <= in_ok[k];
					nrm_q[k] <= '0;
				end
				status_q <= (&in_ok) ? fste_pkg::ST_OK : fste_pkg::ST_RANGE;
			end
			fste_pkg::OP_DIFF: begin
				ux_q <= DW'(signed'(vx_q[1])) - DW'(signed'(vx_q[0]));
				uy_q <= DW'(signed'(vy_q[1])) - DW'(signed'(vy_q[0]));
				uz_q <= DW'(signed'(vz_q[1])) - DW'(signed'(vz_q[0]));
				wx_q <= DW'(signed'(vx_q[2])) - DW'(signed'(vx_q[0]));
				wy_q <= DW'(signed'(vy_q[2])) - DW'(signed'(vy_q[0]));
				wz_q <= DW'(signed'(vz_q[2])) - DW'(signed'(vz_q[0]));
			end
			fste_pkg::OP_MAG: begin
				for (int k = 0; k < 3; k++) begin
					m_q[k] <= MW'(cr_q[k][RW-1] ? -cr_q[k] : cr_q[k]);
				end
				if (stat.zero) status_q <= fste_pkg::ST_DEGEN;
			end
			// Scale all magnitudes by one bit toward [2^29, 2^30).
			fste_pkg::OP_NORM: begin
				for (int k = 0; k < 3; k++) begin
					m_q[k] <= norm_hi ? (m_q[k] >> 1) : (m_q[k] << 1);
				end
			end
			fste_pkg::OP_SQINIT: begin
				sq_n_q <= sum_q;
				sq_r_q <= '0;
				sq_b_q <= SW'(1) << 60;
			end
			// One digit of the bitwise square root.
			fste_pkg::OP_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			fste_pkg::OP_DIVINIT: begin
				for (int k = 0; k < 3; k++) begin
					logic [NW-1:0] num;
					num = NW'({m_q[k][29:0], 15'b0}) + NW'(len >> 1);
					rem_q[k] <= (LW+1)'(num[NW-1:QW]);
					nlo_q[k] <= num[QW-1:0];
					quo_q[k] <= '0;
				end
			end
			// One restoring divide step in each lane.
			fste_pkg::OP_DIV: begin
				for (int k = 0; k < 3; k++) begin
					logic [LW:0] t;
					t = {rem_q[k][LW-1:0], nlo_q[k][QW-1]};
					if (t >= {1'b0, len}) begin
						rem_q[k] <= t - {1'b0, len};
						quo_q[k] <= {quo_q[k][QW-2:0], 1'b1};
					end else begin
						rem_q[k] <= t;
						quo_q[k] <= {quo_q[k][QW-2:0], 1'b0};
					end
					nlo_q[k] <= nlo_q[k] << 1;
				end
			end
			// Saturate and apply the cross product sign.
			fste_pkg::OP_FIN: begin
				for (int k = 0; k < 3; k++) begin
					logic [HW-1:0] q;
					q = (quo_q[k] > QW'(32767)) ? HW'(32767) : HW'(quo_q[k]);
					nrm_q[k] <= cr_q[k][RW-1] ? -q : q;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load a corner, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == fste_pkg::OP_EMIT) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == fste_pkg::OP_EMIT) begin
			out_data <= {nrm_q[2], nrm_q[1], nrm_q[0],
				ok_q[cmd.sel[1:0]] ? vz_q[cmd.sel[1:0]] : PW'(0),
				ok_q[cmd.sel[1:0]] ? vy_q[cmd.sel[1:0]] : PW'(0),
				ok_q[cmd.sel[1:0]] ? vx_q[cmd.sel[1:0]] : PW'(0)};
			out_user <= {status_q, cmd.sel[1:0]};
			out_last <= (cmd.sel[1:0] == 2'd2);
		end
	end

	assign stat.all_ok    = &ok_q;
	assign stat.zero      = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
	assign stat.norm_done = !norm_hi && !norm_lo;
	assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== hw/rtl/flat_shaded_triangle_expander.sv =====
// Flat shaded triangle expander: top level joining fste_ctrl and fste_dp.
// Depends on fste_pkg, fste_ctrl and fste_dp.
//
// Slave stream: tuser carries the command. A store beat appends one Q12.12
// vertex to the store; a beat that arrives with the store full
// is dropped. A face beat names three vertices by 1-based number and yields
// three master beats, corners a, b, c, each with that corner's position and
// the shared Q1.15 unit normal; the third carries tlast. tuser on the master
// side holds the corner and a status (ok, index out of range, degenerate).
// A face with a bad index goes to its first beat after the reads, a degenerate
// one after the magnitudes. A good face passes the reads and differences, the
// cross product on one shared 31x31 multiplier and the magnitudes, normalizing
// (one bit a cycle), the squares, the bitwise square root (one digit a cycle),
// three divider lanes (one quotient bit a cycle) and the sign, then loads the
// first beat; the other two follow.
// One face is worked on at a time; slave tready rises again once the third
// beat is in the output register, so the next beat is taken while it waits.
// A stalled master holds the output register and the sequence in place.
// Reset empties the store (fill count zero) and drops any pending beat.
module flat_shaded_triangle_expander #(
	parameter int unsigned VERTEX_DEPTH = fste_pkg::VERTEX_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x[23:0], pos_y[47:24], pos_z[71:48], index_a[87:72], index_b[103:88],
	// index_c[119:104]
	input  logic [119:0] s_tdata,
	// cmd[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[23:0], out_y[47:24], out_z[71:48], normal_x[87:72],
	// normal_y[103:88], normal_z[119:104]
	output logic [119:0] m_tdata,
	// corner[1:0], status[3:2]
	output logic [3:0]   m_tuser,
	output logic         m_tlast
);

	fste_pkg::dp_cmd_t  cmd;
	fste_pkg::dp_stat_t stat;

	fste_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser[0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fste_dp #(
		.VERTEX_DEPTH (VERTEX_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== hw/rtl/fste_checker.sv =====
// Port-level checks for the triangle expander, bound to the top level.
// Depends on fste_pkg.
module fste_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [119:0] s_tdata,
	input logic [0:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata,
	input logic [3:0]   m_tuser,
	input logic         m_tlast
);

	// A stalled beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("master beat changed while stalled");

	// tlast marks exactly the third corner.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[1:0] == 2'd2)))
		else $error("tlast does not match corner");

	// A faulted face carries a zero normal.
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:2] != fste_pkg::ST_OK) |-> (m_tdata[119:72] == '0))
		else $error("nonzero normal on faulted face");

	// No new item is taken between the first and the last corner.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tuser[1:0] == 2'd0) |=> !s_tready)
		else $error("input taken in the middle of a face");

endmodule

bind flat_shaded_triangle_expander fste_checker u_chk (.*);
